// ----- hw/rtl/led_wire_formatter_assert.svh -----
// Assertion macros, sampled on clk and disabled while rst_n is low.
`ifndef LED_WIRE_FORMATTER_ASSERT_SVH
`define LED_WIRE_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define LWF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LWF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lwf_pkg.sv -----
`timescale 1ns / 1ps

package lwf_pkg;

    localparam int MAX_PIXELS_DEF  = 512;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int START_LEN       = 4;
    localparam int TRAIL_BASE      = 4;
    localparam int TRAIL_SHIFT     = 4;
    localparam int LEN_W           = 3;

    localparam logic [1:0] FMT_PLAIN   = 2'd0;
    localparam logic [1:0] FMT_FRAMED  = 2'd1;
    localparam logic [1:0] FMT_FLIPDOT = 2'd2;

    localparam logic [2:0] ORD_RGB  = 3'd0;
    localparam logic [2:0] ORD_GRB  = 3'd1;
    localparam logic [2:0] ORD_BGR  = 3'd2;
    localparam logic [2:0] ORD_RGBW = 3'd3;
    localparam logic [2:0] ORD_GRBW = 3'd4;

    localparam logic CFG_WIRE_FORMAT = 1'b0;
    localparam logic CFG_COLOR_ORDER = 1'b1;

    localparam logic [7:0] START_BYTE = 8'h00;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] HDR_BYTE   = 8'hE0;
    localparam logic [7:0] DOT_LIT    = 8'h00;
    localparam logic [7:0] DOT_DARK   = 8'hFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
        logic [4:0] brightness;
        logic       last_pixel;
    } pix_t;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       run_end;
        logic       frame_end;
    } wire_t;

    typedef struct packed {
        logic                  pre;
        logic [3:0][7:0]       body;
        logic [LEN_W-1:0]      body_len;
        logic                  trail;
        logic                  frame_last;
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRE,
        PH_BODY,
        PH_TRAIL
    } phase_t;

endpackage

// ----- hw/rtl/led_wire_formatter.sv -----
`timescale 1ns / 1ps
// LED wire formatter: one pixel beat in on pix_*, wire byte beats out on wire_*.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// cfg_we with cfg_index selects wire_format (0) or color_order (1); write only
// while no frame bytes are outstanding.
// Per pixel: plain format gives 3 or 4 bytes, framed format 4 bytes plus four
// start bytes on the first pixel and (count+1)/16+4 fill bytes after the last,
// flipdot format one 3-byte group per three dots (or at the last pixel).
// run_end marks the last byte of a pixel, frame_end the last byte of a frame.
// A taken pixel beat goes into the command queue, then the command register,
// then the output register. The output sequencer gives one wire byte per cycle
// while wire_stall is low, start and fill bytes included.
// A 2-entry command queue decouples pixel intake from byte output; pixels
// keep flowing while a byte waits in the output register.
// Reset clears the frame state, the queue and both registers to plain RGB.
// When the receiver stalls, the output byte holds and the queue fills, after
// which pix_stall rises.
module led_wire_formatter
    import lwf_pkg::*;
#(
    parameter int MaxPixels  = MAX_PIXELS_DEF,
    parameter int QueueDepth = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_stall,
    input  pix_t       pix_data,
    output logic       wire_valid,
    input  logic       wire_stall,
    output wire_t      wire_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data
);

    localparam int TrailW = $clog2(((MaxPixels + 1) >> TRAIL_SHIFT) + TRAIL_BASE + 1);
    localparam int QW     = $bits(cmd_t) + TrailW;

    logic              q_full, q_push, q_pop, q_valid;
    cmd_t              push_cmd, pop_cmd;
    logic [TrailW-1:0] push_trail, pop_trail;

    lwf_front #(
        .MaxPixels (MaxPixels),
        .TrailW    (TrailW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_data    (pix_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_trail_cnt (push_trail)
    );

    lwf_queue #(
        .Width (QW),
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_trail, push_cmd}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  ({pop_trail, pop_cmd})
    );

    lwf_back #(
        .TrailW (TrailW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (pop_cmd),
        .q_trail_cnt (pop_trail),
        .q_pop       (q_pop),
        .wire_valid  (wire_valid),
        .wire_stall  (wire_stall),
        .wire_data   (wire_data)
    );

endmodule

// ----- hw/rtl/lwf_front.sv -----
`timescale 1ns / 1ps

module lwf_front
    import lwf_pkg::*;
#(
    parameter int MaxPixels = MAX_PIXELS_DEF,
    parameter int TrailW    = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  pix_t              pix_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [2:0]        cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd,
    output logic [TrailW-1:0] q_trail_cnt
);

    localparam int CountW = $clog2(MaxPixels + 1);

    logic [1:0]        wire_format_reg;
    logic [2:0]        color_order_reg;
    logic [CountW-1:0] pc_reg, pc_next, pc_inc;
    logic [1:0]        gp_reg, gp_next;
    logic [1:0]        held_reg, held_next;
    logic              accept, enq, first, lit, d0, d1, d2;
    logic [CountW:0]   pc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wire_format_reg <= FMT_PLAIN;
            color_order_reg <= ORD_RGB;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIRE_FORMAT: wire_format_reg <= cfg_data[1:0];
                CFG_COLOR_ORDER: color_order_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            gp_reg   <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            pc_reg   <= pc_next;
            gp_reg   <= gp_next;
            held_reg <= held_next;
        end
    end

    assign pix_stall = q_full;
    assign accept    = pix_valid && !q_full;
    assign q_push    = accept && enq;

    always_comb
    begin
        first  = (pc_reg == '0);
        pc_inc = (pc_reg < CountW'(MaxPixels)) ? pc_reg + 1'b1 : pc_reg;
        pc_sum = {1'b0, pc_inc} + 1'b1;
        q_trail_cnt = TrailW'(pc_sum >> TRAIL_SHIFT) + TrailW'(TRAIL_BASE);
        lit = |{pix_data.red, pix_data.green, pix_data.blue, pix_data.white};
        d0 = 1'b0;
        d1 = 1'b0;
        d2 = 1'b0;

        pc_next   = pc_inc;
        gp_next   = gp_reg;
        held_next = held_reg;
        enq       = 1'b1;
        q_cmd.pre        = 1'b0;
        q_cmd.body       = '0;
        q_cmd.body_len   = LEN_W'(3);
        q_cmd.trail      = 1'b0;
        q_cmd.frame_last = pix_data.last_pixel;

        case (wire_format_reg)
            FMT_FRAMED:
            begin
                q_cmd.pre      = first;
                q_cmd.body[0]  = HDR_BYTE | {3'b000, pix_data.brightness};
                q_cmd.body_len = LEN_W'(4);
                q_cmd.trail    = pix_data.last_pixel;
                if (color_order_reg == ORD_BGR)
                begin
                    q_cmd.body[1] = pix_data.blue;
                    q_cmd.body[2] = pix_data.green;
                    q_cmd.body[3] = pix_data.red;
                end
                else
                begin
                    q_cmd.body[1] = pix_data.red;
                    q_cmd.body[2] = pix_data.green;
                    q_cmd.body[3] = pix_data.blue;
                end
            end
            FMT_FLIPDOT:
            begin
                if (gp_reg < 2'd2 && !pix_data.last_pixel)
                begin
                    enq       = 1'b0;
                    held_next = held_reg | (2'({1'b0, lit}) << gp_reg);
                    gp_next   = gp_reg + 1'b1;
                end
                else
                begin
                    case (gp_reg)
                        2'd0:
                        begin
                            d0 = lit;
                        end
                        2'd1:
                        begin
                            d0 = held_reg[0];
                            d1 = lit;
                        end
                        default:
                        begin
                            d0 = held_reg[0];
                            d1 = held_reg[1];
                            d2 = lit;
                        end
                    endcase
                    q_cmd.body[0] = d1 ? DOT_LIT : DOT_DARK;
                    q_cmd.body[1] = d0 ? DOT_LIT : DOT_DARK;
                    q_cmd.body[2] = d2 ? DOT_LIT : DOT_DARK;
                    gp_next   = '0;
                    held_next = '0;
                end
            end
            default:
            begin
                case (color_order_reg)
                    ORD_GRB, ORD_GRBW:
                    begin
                        q_cmd.body[0] = pix_data.green;
                        q_cmd.body[1] = pix_data.red;
                        q_cmd.body[2] = pix_data.blue;
                    end
                    ORD_BGR:
                    begin
                        q_cmd.body[0] = pix_data.blue;
                        q_cmd.body[1] = pix_data.green;
                        q_cmd.body[2] = pix_data.red;
                    end
                    default:
                    begin
                        q_cmd.body[0] = pix_data.red;
                        q_cmd.body[1] = pix_data.green;
                        q_cmd.body[2] = pix_data.blue;
                    end
                endcase
                if (color_order_reg == ORD_RGBW || color_order_reg == ORD_GRBW)
                begin
                    q_cmd.body[3]  = pix_data.white;
                    q_cmd.body_len = LEN_W'(4);
                end
            end
        endcase

        // end of frame: drop all per-frame state
        if (pix_data.last_pixel)
        begin
            pc_next   = '0;
            gp_next   = '0;
            held_next = '0;
        end
    end

endmodule

// ----- hw/rtl/lwf_queue.sv -----
`timescale 1ns / 1ps

module lwf_queue
    import lwf_pkg::*;
#(
    parameter int Width = 8,
    parameter int Depth = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [Width-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [Width-1:0] pop_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] mem [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]  count_reg;

    assign full      = (count_reg == CntW'(Depth));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/lwf_back.sv -----
`timescale 1ns / 1ps

module lwf_back
    import lwf_pkg::*;
#(
    parameter int TrailW = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    input  logic [TrailW-1:0] q_trail_cnt,
    output logic              q_pop,
    output logic              wire_valid,
    input  logic              wire_stall,
    output wire_t             wire_data
);

`include "led_wire_formatter_assert.svh"

    phase_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [TrailW-1:0] trail_reg, trail_next;
    logic [TrailW-1:0] idx_reg, idx_next;
    logic              wire_valid_reg, wire_valid_next;
    wire_t             wire_reg, wire_next;
    logic              advance, emit, final_byte;
    logic [7:0]        cur_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= PH_IDLE;
            wire_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wire_valid_reg <= wire_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        trail_reg <= trail_next;
        idx_reg   <= idx_next;
        wire_reg  <= wire_next;
    end

    assign wire_valid = wire_valid_reg;
    assign wire_data  = wire_reg;

    always_comb
    begin
        advance    = !wire_valid_reg || !wire_stall;
        cur_byte   = START_BYTE;
        final_byte = 1'b0;
        case (state_reg)
            PH_BODY:
            begin
                cur_byte   = cmd_reg.body[idx_reg[1:0]];
                final_byte = (idx_reg == TrailW'(cmd_reg.body_len - 1'b1)) && !cmd_reg.trail;
            end
            PH_TRAIL:
            begin
                cur_byte   = FILL_BYTE;
                final_byte = (idx_reg == trail_reg - 1'b1);
            end
            default: ;
        endcase
        emit  = advance && (state_reg != PH_IDLE);
        q_pop = q_valid && ((state_reg == PH_IDLE) || (emit && final_byte));

        state_next = state_reg;
        cmd_next   = cmd_reg;
        trail_next = trail_reg;
        idx_next   = idx_reg;
        if (emit)
        begin
            idx_next = idx_reg + 1'b1;
            case (state_reg)
                PH_PRE:
                begin
                    if (idx_reg == TrailW'(START_LEN - 1))
                    begin
                        state_next = PH_BODY;
                        idx_next   = '0;
                    end
                end
                PH_BODY:
                begin
                    if (idx_reg == TrailW'(cmd_reg.body_len - 1'b1))
                    begin
                        state_next = cmd_reg.trail ? PH_TRAIL : PH_IDLE;
                        idx_next   = '0;
                    end
                end
                PH_TRAIL:
                begin
                    if (final_byte)
                    begin
                        state_next = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
        if (q_pop)
        begin
            cmd_next   = q_cmd;
            trail_next = q_trail_cnt;
            idx_next   = '0;
            state_next = q_cmd.pre ? PH_PRE : PH_BODY;
        end

        wire_valid_next = wire_valid_reg;
        wire_next       = wire_reg;
        if (advance)
        begin
            wire_valid_next     = emit;
            wire_next.wire_byte = cur_byte;
            wire_next.run_end   = final_byte;
            wire_next.frame_end = final_byte && cmd_reg.frame_last;
        end
    end

    `LWF_ASSERT_IMP(a_frame_end_on_run_end, wire_valid_reg && wire_reg.frame_end,
        wire_reg.run_end, "frame end without run end")
    `LWF_ASSERT_IMP(a_pop_needs_entry, q_pop, q_valid, "pop from empty queue")
    `LWF_ASSERT_IMP(a_trail_in_range, state_reg == PH_TRAIL, idx_reg < trail_reg,
        "trailer index past its count")
    `LWF_ASSERT_NXT(a_idle_no_byte,
        state_reg == PH_IDLE && !q_valid && (!wire_valid_reg || !wire_stall),
        !wire_valid_reg, "byte produced while idle")

endmodule
